// ===== hdl/wsee_pkg.sv =====
// ----------------------------------------------------------------------------
// wsee_pkg
// Shared types and constants of the windowed sparse event encoder: the
// controller state, the controller/datapath command and status groups, the
// result item layout and a few fixed sizes.
// ----------------------------------------------------------------------------
package wsee_pkg;

	// payload store size, fixed by the byte address field
	localparam int PAYLOAD_BYTES = 16;
	localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

	// width of lane positions, cursors and window bases
	localparam int POS_W = 10;

	// events emitted per request at most, the rest are only counted
	localparam int MAX_EVENTS = 32;

	// reset value of the width register
	localparam logic [7:0] WIDTH_RESET = 8'd128;

	// count saturation limit
	localparam logic [7:0] SAT_LIMIT = 8'd63;

	// request codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_ENCODE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_SCAN,
		ST_SUMM,
		ST_ERR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_byte;
		logic latch;
		logic calc_div;
		logic init;
		logic step;
		logic summ;
		logic err;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic width_ok;
		logic done;
		logic slot_free;
	} dp_stat_t;

	// one result item
	typedef struct packed {
		logic [6:0] event_index;
		logic       is_summary;
		logic [5:0] lane_event_count;
		logic [5:0] lane_cycles;
		logic [7:0] total_events;
		logic [5:0] max_lane_cycles;
		logic       width_error;
		logic       last;
	} res_t;

	// clamp a count to six bits
	function automatic logic [5:0] sat63(input logic [7:0] v);
		logic [5:0] r;
		r = (v > SAT_LIMIT) ? 6'd63 : v[5:0];
		return r;
	endfunction

endpackage

// ===== hdl/wsee_intf.sv =====
// ----------------------------------------------------------------------------
// wsee interfaces
// Valid/ready channels of the encoder: request, result and width register
// write.
// ----------------------------------------------------------------------------
interface wsee_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [3:0] byte_address;
	logic [7:0] byte_value;
	logic [1:0] lane_select;

	modport source (output valid, func, byte_address, byte_value, lane_select, input ready);
	modport sink (input valid, func, byte_address, byte_value, lane_select, output ready);
endinterface

interface wsee_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] event_index;
	logic       is_summary;
	logic [5:0] lane_event_count;
	logic [5:0] lane_cycles;
	logic [7:0] total_events;
	logic [5:0] max_lane_cycles;
	logic       width_error;
	logic       last;

	modport source (output valid, event_index, is_summary, lane_event_count, lane_cycles,
		total_events, max_lane_cycles, width_error, last, input ready);
	modport sink (input valid, event_index, is_summary, lane_event_count, lane_cycles,
		total_events, max_lane_cycles, width_error, last, output ready);
endinterface

interface wsee_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/windowed_sparse_event_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_sparse_event_encoder_unit
// Top level: loads a payload bit vector byte by byte and encodes one lane at
// a time into set-bit indices followed by a summary.
// ----------------------------------------------------------------------------
// A payload byte write is taken while idle and gives no result. An encode
// request runs through lane setup (ST_DIV: lane width by reciprocal
// multiply, then ST_CHECK: the width check and lane start), then the scan
// steps, where a step emits one set bit (only counted once MAX_EVENTS are
// out) or skips past empty windows, then sees the lane finished and loads
// the summary. A step waits whenever the output register is full and not
// being taken. The next request is taken as soon as the summary sits in the
// output register. An invalid width or lane gives a single error summary.
module windowed_sparse_event_encoder_unit
	import wsee_pkg::*;
#(
	parameter int WINDOW    = 8,
	parameter int LANES     = 4,
	parameter int MAX_WIDTH = 128
) (
	input logic        clk,
	input logic        arst_n,
	wsee_cfg_if.sink   cfg,
	wsee_req_if.sink   cmd,
	wsee_res_if.source res
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	res_t     res_item;
	logic     res_valid;

	// width register is always writable
	assign cfg.ready = 1'b1;

	// controller
	wsee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_func  (cmd.func),
		.req_ready (cmd.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// datapath
	wsee_dp #(
		.WINDOW    (WINDOW),
		.LANES     (LANES),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.byte_address (cmd.byte_address),
		.byte_value   (cmd.byte_value),
		.lane_select  (cmd.lane_select),
		.res_ready    (res.ready),
		.res_valid    (res_valid),
		.res          (res_item)
	);

	// result channel
	assign res.valid            = res_valid;
	assign res.event_index      = res_item.event_index;
	assign res.is_summary       = res_item.is_summary;
	assign res.lane_event_count = res_item.lane_event_count;
	assign res.lane_cycles      = res_item.lane_cycles;
	assign res.total_events     = res_item.total_events;
	assign res.max_lane_cycles  = res_item.max_lane_cycles;
	assign res.width_error      = res_item.width_error;
	assign res.last             = res_item.last;

	// an encode request blocks further requests until its summary is loaded
	a_encode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && (cmd.func == FUNC_ENCODE) |=> !cmd.ready)
		else $error("request taken during lane setup");

	// a lane never reports more events than cycles
	a_cycles_cover_events: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_summary |-> res.lane_cycles >= res.lane_event_count)
		else $error("lane event count exceeds cycle count");

	// error summaries carry no lane counts
	a_error_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.width_error |->
			res.lane_event_count == 6'd0 && res.lane_cycles == 6'd0 && res.last)
		else $error("error summary with lane counts");

	// the last flag marks summaries only
	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.last == res.is_summary))
		else $error("last flag out of step with summary");

endmodule

// ===== hdl/wsee_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsee_ctrl
// Controller of the encoder: takes requests while idle, sequences the lane
// setup, the window scan steps and the closing summary or error summary.
// ----------------------------------------------------------------------------
module wsee_ctrl
	import wsee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_func,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_func == FUNC_WRITE) begin
						cmd.wr_byte = 1'b1;
					end else begin
						cmd.latch = 1'b1;
						state_n   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.calc_div = 1'b1;
				state_n      = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.init = 1'b1;
				state_n  = stat.width_ok ? ST_SCAN : ST_ERR;
			end
			ST_SCAN: begin
				if (stat.done) begin
					state_n = ST_SUMM;
				end else if (stat.slot_free) begin
					cmd.step = 1'b1;
				end
			end
			ST_SUMM: begin
				if (stat.slot_free) begin
					cmd.summ = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (stat.slot_free) begin
					cmd.err = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/wsee_dp.sv =====
// ----------------------------------------------------------------------------
// wsee_dp
// Datapath of the encoder: payload store, width register, lane setup, the
// two-window scan step with its priority encoders, running totals and the
// output register.
// ----------------------------------------------------------------------------
module wsee_dp
	import wsee_pkg::*;
#(
	parameter int WINDOW    = 8,
	parameter int LANES     = 4,
	parameter int MAX_WIDTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic [3:0] byte_address,
	input  logic [7:0] byte_value,
	input  logic [1:0] lane_select,
	input  logic       res_ready,
	output logic       res_valid,
	output res_t       res
);

	localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RECIP = (65536 + LANES - 1) / LANES;
	localparam logic [POS_W-1:0] W1 = POS_W'(WINDOW);
	localparam logic [POS_W-1:0] W2 = POS_W'(2 * WINDOW);
	localparam logic [IW-1:0] LAST_OFS = IW'(WINDOW - 1);

	logic [PAYLOAD_BYTES-1:0][7:0] payload_q;
	logic [7:0]       width_q;
	logic [1:0]       lane_q;
	logic [7:0]       lw_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] cursor_q;
	logic [POS_W-1:0] ws_q;
	logic [7:0]       cnt_q;
	logic [7:0]       cyc_q;
	logic [7:0]       sum_q;
	logic [5:0]       max_q;
	logic             out_valid_q;
	res_t             res_q;

	// payload store and width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= '0;
			width_q   <= WIDTH_RESET;
		end else begin
			if (cmd.wr_byte) begin
				payload_q[byte_address] <= byte_value;
			end
			if (cfg_we) begin
				width_q <= cfg_data;
			end
		end
	end

	// lane width by reciprocal multiply, exact for 8-bit widths
	logic [24:0] lw_prod;
	assign lw_prod = 25'(width_q) * 25'(RECIP);

	// width and lane checks, evaluated while lw_q holds the quotient
	logic [11:0] lw_back;
	assign lw_back = 12'(lw_q) * 12'(LANES);
	assign stat.width_ok = (width_q != 8'd0) && (32'(width_q) <= MAX_WIDTH)
		&& (32'(width_q) >= LANES) && (lw_back == 12'(width_q))
		&& (32'(lane_q) < LANES);

	logic [POS_W-1:0] lw_ext;
	assign lw_ext = POS_W'(lw_q);

	// two windows of payload bits from the current window base
	logic [PAYLOAD_BITS+2*WINDOW-1:0] ext_bits, shifted;
	logic [2*WINDOW-1:0]              win;
	logic [POS_W-1:0]                 base_pos;
	assign base_pos = start_q + ws_q;
	assign ext_bits = {{(2*WINDOW){1'b0}}, payload_q};
	assign shifted  = ext_bits >> base_pos;
	assign win      = shifted[2*WINDOW-1:0];

	// masks: first window from the cursor, second window inside the lane
	logic [WINDOW-1:0] m1, m2;
	always_comb begin
		logic [POS_W-1:0] p1, p2;
		for (int j = 0; j < WINDOW; j++) begin
			p1 = ws_q + POS_W'(j);
			p2 = ws_q + W1 + POS_W'(j);
			m1[j] = win[j] && (p1 >= cursor_q) && (p1 < lw_ext);
			m2[j] = win[WINDOW+j] && (p2 < lw_ext);
		end
	end

	// lowest set bit in each window
	logic          f1, f2;
	logic [IW-1:0] i1, i2;
	always_comb begin
		f1 = 1'b0;
		f2 = 1'b0;
		i1 = '0;
		i2 = '0;
		for (int j = WINDOW - 1; j >= 0; j--) begin
			if (m1[j]) begin
				f1 = 1'b1;
				i1 = IW'(j);
			end
			if (m2[j]) begin
				f2 = 1'b1;
				i2 = IW'(j);
			end
		end
	end

	// next cursor and window base after one scan step
	logic             hit;
	logic [POS_W-1:0] hit_pos, cursor_n, ws_n;
	always_comb begin
		hit      = f1 || f2;
		hit_pos  = ws_q + POS_W'(i1);
		cursor_n = ws_q + W2;
		ws_n     = ws_q + W2;
		if (f1) begin
			hit_pos  = ws_q + POS_W'(i1);
			cursor_n = hit_pos + POS_W'(1);
			ws_n     = (i1 == LAST_OFS) ? ws_q + W1 : ws_q;
		end else if (f2) begin
			hit_pos  = ws_q + W1 + POS_W'(i2);
			cursor_n = hit_pos + POS_W'(1);
			ws_n     = (i2 == LAST_OFS) ? ws_q + W2 : ws_q + W1;
		end
	end

	assign stat.done = (cursor_q >= lw_ext);

	// running totals for a finished lane
	logic [7:0] sum_base, sum_new;
	logic [8:0] sum_add;
	logic [5:0] max_base, max_new, cyc_sat;
	always_comb begin
		sum_base = (lane_q == 2'd0) ? 8'd0 : sum_q;
		max_base = (lane_q == 2'd0) ? 6'd0 : max_q;
		sum_add  = 9'(sum_base) + 9'(cnt_q);
		sum_new  = sum_add[8] ? 8'hFF : sum_add[7:0];
		cyc_sat  = sat63(cyc_q);
		max_new  = (cyc_sat > max_base) ? cyc_sat : max_base;
	end

	// event result item
	res_t ev_item;
	always_comb begin
		ev_item             = '0;
		ev_item.event_index = 7'(start_q + hit_pos);
	end

	// emit gating and output slot
	logic emit_ev, load;
	assign emit_ev        = cmd.step && hit && (cnt_q < 8'(MAX_EVENTS));
	assign load           = emit_ev || cmd.summ || cmd.err;
	assign stat.slot_free = !out_valid_q || res_ready;

	// lane setup and scan registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			lane_q <= lane_select;
		end
		if (cmd.calc_div) begin
			lw_q <= lw_prod[23:16];
		end
		if (cmd.init) begin
			start_q  <= POS_W'(lane_q) * lw_ext;
			cursor_q <= '0;
			ws_q     <= '0;
			cnt_q    <= '0;
			cyc_q    <= '0;
		end
		if (cmd.step) begin
			cursor_q <= cursor_n;
			ws_q     <= ws_n;
			cyc_q    <= cyc_q + 8'd1;
			if (hit) begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			max_q <= '0;
		end else if (cmd.summ) begin
			sum_q <= sum_new;
			max_q <= max_new;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_ev) begin
			res_q <= ev_item;
		end else if (cmd.summ) begin
			res_q.event_index      <= '0;
			res_q.is_summary       <= 1'b1;
			res_q.lane_event_count <= sat63(cnt_q);
			res_q.lane_cycles      <= cyc_sat;
			res_q.total_events     <= sum_new;
			res_q.max_lane_cycles  <= max_new;
			res_q.width_error      <= 1'b0;
			res_q.last             <= 1'b1;
		end else if (cmd.err) begin
			res_q.event_index      <= '0;
			res_q.is_summary       <= 1'b1;
			res_q.lane_event_count <= '0;
			res_q.lane_cycles      <= '0;
			res_q.total_events     <= sum_q;
			res_q.max_lane_cycles  <= max_q;
			res_q.width_error      <= 1'b1;
			res_q.last             <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule
